// ===== rtl/fr_pkg.sv =====
package fr_pkg;

    localparam int SQ_STEPS  = 29;
    localparam int DIV_STEPS = 29;
    localparam int RAT_STEPS = 19;

    localparam logic [28:0] ONE_Q28  = 29'h1000_0000;
    localparam logic [56:0] ONE_Q56  = 57'h100_0000_0000_0000;
    localparam logic [15:0] ONE_Q14  = 16'h4000;
    localparam logic [15:0] OUT_ONE  = 16'h8000;
    localparam logic [18:0] RAT_ONE  = 19'h4_0000;

    typedef struct packed {
        logic signed [15:0] to_origin_x;
        logic signed [15:0] to_origin_y;
        logic signed [15:0] to_origin_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        material_index;
    } fr_in_t;

    typedef struct packed {
        logic [15:0] reflectance;
        logic        total_internal;
        logic        leaving_material;
    } fr_out_t;

    // per-item values that ride along the arithmetic pipes
    typedef struct packed {
        logic        leaving;
        logic        tir;
        logic [28:0] cos_i;
        logic [15:0] n1;
        logic [15:0] n2;
    } fr_side_t;

endpackage

// ===== rtl/fresnel_reflectance.sv =====
// fresnel reflectance, fully pipelined from an accepted input word to
// its result word on m_valid
// throughput one word per cycle, set by the bit-per-stage square root,
// sine division and ratio pipes; a stalled output freezes all stages
// reset (aresetn low, synchronous) clears every valid bit; data regs keep
// whatever they hold
module fresnel_reflectance
    import fr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  fr_in_t  s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output fr_out_t m_data
);

    // whole pipe advances together when the output word can move
    logic en;

    // front: dot product, cosine, 1 - cos^2
    logic        fr_v;
    logic [56:0] fr_rad;
    fr_side_t    fr_side;

    // first root: sine of incidence
    logic        sq1_v;
    logic [28:0] sin_i;
    fr_side_t    sq1_side;

    // sin_i * n1
    logic        mul_v_reg;
    logic [44:0] mul_reg;
    fr_side_t    mul_side_reg;

    // division by n2
    logic        dv_v;
    logic [28:0] dv_quot;
    logic        dv_ovf;
    fr_side_t    dv_side;

    // transmitted sine with total internal reflection check
    logic        st_v_reg;
    logic [28:0] st_reg;
    fr_side_t    st_side_reg;
    fr_side_t    st_side_next;
    logic        tir_next;

    // sin_t squared, then 1 - sin_t^2
    logic        ssq_v_reg;
    logic [57:0] ssq_reg;
    fr_side_t    ssq_side_reg;
    logic        rad2_v_reg;
    logic [56:0] rad2_reg;
    fr_side_t    rad2_side_reg;

    // second root: transmitted cosine
    logic        sq2_v;
    logic [28:0] cos_t;
    fr_side_t    sq2_side;

    // index times cosine terms
    logic        pr_v_reg;
    logic [44:0] a1_reg, b1_reg, a2_reg, b2_reg;
    fr_side_t    pr_side_reg;

    // numerators and denominators for rs and rp
    logic             nd_v_reg;
    logic [1:0][45:0] num_reg;
    logic [1:0][45:0] den_reg;
    fr_side_t         nd_side_reg;

    logic             rt_v;
    logic [1:0][18:0] rt_ratio;
    fr_side_t         rt_side;

    // squared ratios
    logic        rsq_v_reg;
    logic [37:0] rs2_reg, rp2_reg;
    fr_side_t    rsq_side_reg;

    // output word
    logic        out_v_reg;
    fr_out_t     out_reg;
    fr_out_t     out_next;
    logic [38:0] sum;
    logic [16:0] half;

    assign en      = m_ready || !out_v_reg;
    assign s_ready = en;

    fr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (fr_v),
        .out_rad   (fr_rad),
        .out_side  (fr_side)
    );

    fr_sqrt u_sqrt_sin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_v),
        .in_rad    (fr_rad),
        .in_side   (fr_side),
        .out_valid (sq1_v),
        .out_root  (sin_i),
        .out_side  (sq1_side)
    );

    fr_sindiv u_sindiv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (mul_v_reg),
        .in_dividend (mul_reg),
        .in_divisor  (mul_side_reg.n2),
        .in_side     (mul_side_reg),
        .out_valid   (dv_v),
        .out_quot    (dv_quot),
        .out_ovf     (dv_ovf),
        .out_side    (dv_side)
    );

    always_comb begin
        // sin_t above one means no transmitted ray
        tir_next         = dv_ovf || (dv_quot > ONE_Q28);
        st_side_next     = dv_side;
        st_side_next.tir = tir_next;
    end

    fr_sqrt u_sqrt_cos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rad2_v_reg),
        .in_rad    (rad2_reg),
        .in_side   (rad2_side_reg),
        .out_valid (sq2_v),
        .out_root  (cos_t),
        .out_side  (sq2_side)
    );

    fr_ratio u_ratio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (nd_v_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_side   (nd_side_reg),
        .out_valid (rt_v),
        .out_ratio (rt_ratio),
        .out_side  (rt_side)
    );

    always_comb begin
        sum  = 39'(rs2_reg) + 39'(rp2_reg);
        half = sum[38:22];
        out_next.total_internal   = rsq_side_reg.tir;
        out_next.leaving_material = rsq_side_reg.leaving;
        if (rsq_side_reg.tir || (half > 17'(OUT_ONE))) begin
            out_next.reflectance = OUT_ONE;
        end else begin
            out_next.reflectance = half[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg  <= 1'b0;
            st_v_reg   <= 1'b0;
            ssq_v_reg  <= 1'b0;
            rad2_v_reg <= 1'b0;
            pr_v_reg   <= 1'b0;
            nd_v_reg   <= 1'b0;
            rsq_v_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
        end else if (en) begin
            mul_v_reg  <= sq1_v;
            st_v_reg   <= dv_v;
            ssq_v_reg  <= st_v_reg;
            rad2_v_reg <= ssq_v_reg;
            pr_v_reg   <= sq2_v;
            nd_v_reg   <= pr_v_reg;
            rsq_v_reg  <= rt_v;
            out_v_reg  <= rsq_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_reg       <= 45'(sin_i) * 45'(sq1_side.n1);
            mul_side_reg  <= sq1_side;
            st_reg        <= tir_next ? 29'd0 : dv_quot;
            st_side_reg   <= st_side_next;
            ssq_reg       <= 58'(st_reg) * 58'(st_reg);
            ssq_side_reg  <= st_side_reg;
            rad2_reg      <= ONE_Q56 - ssq_reg[56:0];
            rad2_side_reg <= ssq_side_reg;
            a1_reg        <= 45'(sq2_side.n1) * 45'(sq2_side.cos_i);
            b1_reg        <= 45'(sq2_side.n2) * 45'(cos_t);
            a2_reg        <= 45'(sq2_side.n2) * 45'(sq2_side.cos_i);
            b2_reg        <= 45'(sq2_side.n1) * 45'(cos_t);
            pr_side_reg   <= sq2_side;
            num_reg[0]    <= (a1_reg >= b1_reg) ? 46'(a1_reg - b1_reg) : 46'(b1_reg - a1_reg);
            den_reg[0]    <= 46'(a1_reg) + 46'(b1_reg);
            num_reg[1]    <= (a2_reg >= b2_reg) ? 46'(a2_reg - b2_reg) : 46'(b2_reg - a2_reg);
            den_reg[1]    <= 46'(a2_reg) + 46'(b2_reg);
            nd_side_reg   <= pr_side_reg;
            rs2_reg       <= 38'(rt_ratio[0]) * 38'(rt_ratio[0]);
            rp2_reg       <= 38'(rt_ratio[1]) * 38'(rt_ratio[1]);
            rsq_side_reg  <= rt_side;
            out_reg       <= out_next;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/fr_front.sv =====
module fr_front
    import fr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  fr_in_t      in_data,
    output logic        out_valid,
    output logic [56:0] out_rad,
    output fr_side_t    out_side
);

    // stage 0: input word
    logic   v0_reg;
    fr_in_t d0_reg;

    // stage 1: products
    logic               v1_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [15:0]        idx_reg;

    // stage 2: cosine and side
    logic     v2_reg;
    fr_side_t s2_reg;
    fr_side_t s2_next;

    // stage 3: cosine squared
    logic        v3_reg;
    logic [57:0] csq_reg;
    fr_side_t    s3_reg;

    // stage 4: radicand
    logic        v4_reg;
    logic [56:0] rad_reg;
    fr_side_t    s4_reg;

    logic signed [33:0] dot;
    logic [33:0]        mag;

    always_comb begin
        dot = 34'(px_reg) + 34'(py_reg) + 34'(pz_reg);
        mag = dot[33] ? 34'(-dot) : 34'(dot);
        s2_next.leaving = dot[33];
        s2_next.tir     = 1'b0;
        s2_next.cos_i   = (mag > 34'(ONE_Q28)) ? ONE_Q28 : mag[28:0];
        s2_next.n1      = dot[33] ? idx_reg : ONE_Q14;
        s2_next.n2      = dot[33] ? ONE_Q14 : idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_reg  <= in_data;
            px_reg  <= 32'(d0_reg.to_origin_x) * 32'(d0_reg.normal_x);
            py_reg  <= 32'(d0_reg.to_origin_y) * 32'(d0_reg.normal_y);
            pz_reg  <= 32'(d0_reg.to_origin_z) * 32'(d0_reg.normal_z);
            // zero index would divide by zero, use one lsb
            idx_reg <= (d0_reg.material_index == 16'd0) ? 16'd1 : d0_reg.material_index;
            s2_reg  <= s2_next;
            csq_reg <= 58'(s2_reg.cos_i) * 58'(s2_reg.cos_i);
            s3_reg  <= s2_reg;
            rad_reg <= ONE_Q56 - csq_reg[56:0];
            s4_reg  <= s3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_rad   = rad_reg;
    assign out_side  = s4_reg;

endmodule

// ===== rtl/fr_sqrt.sv =====
module fr_sqrt
    import fr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [56:0] in_rad,
    input  fr_side_t    in_side,
    output logic        out_valid,
    output logic [28:0] out_root,
    output fr_side_t    out_side
);

    // one root bit per stage, digit-by-digit floor square root
    logic [SQ_STEPS-1:0] v_reg;
    logic [56:0]         rem_reg  [0:SQ_STEPS-1];
    logic [57:0]         root_reg [0:SQ_STEPS-1];
    fr_side_t            side_reg [0:SQ_STEPS-1];

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_stage
        localparam logic [57:0] BIT = 58'd1 << (2 * (SQ_STEPS - 1 - g));
        logic        pv;
        logic [56:0] prem;
        logic [57:0] proot;
        fr_side_t    pside;
        logic [57:0] trial;
        logic [56:0] rem_next;
        logic [57:0] root_next;

        if (g == 0) begin : g_first
            assign pv    = in_valid;
            assign prem  = in_rad;
            assign proot = '0;
            assign pside = in_side;
        end else begin : g_rest
            assign pv    = v_reg[g-1];
            assign prem  = rem_reg[g-1];
            assign proot = root_reg[g-1];
            assign pside = side_reg[g-1];
        end

        always_comb begin
            trial = proot + BIT;
            if ({1'b0, prem} >= trial) begin
                rem_next  = prem - trial[56:0];
                root_next = (proot >> 1) + BIT;
            end else begin
                rem_next  = prem;
                root_next = proot >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= pv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                side_reg[g] <= pside;
            end
        end
    end

    assign out_valid = v_reg[SQ_STEPS-1];
    assign out_root  = root_reg[SQ_STEPS-1][28:0];
    assign out_side  = side_reg[SQ_STEPS-1];

endmodule

// ===== rtl/fr_sindiv.sv =====
module fr_sindiv
    import fr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [44:0] in_dividend,
    input  logic [15:0] in_divisor,
    input  fr_side_t    in_side,
    output logic        out_valid,
    output logic [28:0] out_quot,
    output logic        out_ovf,
    output fr_side_t    out_side
);

    // restoring division, one quotient bit per stage; a quotient of
    // 2^29 or more is only flagged
    logic [DIV_STEPS-1:0] v_reg;
    logic [15:0]          rem_reg  [0:DIV_STEPS-1];
    logic [28:0]          low_reg  [0:DIV_STEPS-1];
    logic [28:0]          quot_reg [0:DIV_STEPS-1];
    logic [15:0]          dsr_reg  [0:DIV_STEPS-1];
    logic                 ovf_reg  [0:DIV_STEPS-1];
    fr_side_t             side_reg [0:DIV_STEPS-1];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_stage
        localparam int K = DIV_STEPS - 1 - g;
        logic        pv;
        logic [15:0] prem;
        logic [28:0] plow;
        logic [28:0] pquot;
        logic [15:0] pdsr;
        logic        povf;
        fr_side_t    pside;
        logic [16:0] t;
        logic [15:0] rem_next;
        logic [28:0] quot_next;

        if (g == 0) begin : g_first
            logic ovf0;
            assign ovf0  = in_dividend[44:29] >= in_divisor;
            assign pv    = in_valid;
            assign prem  = ovf0 ? 16'd0 : in_dividend[44:29];
            assign plow  = in_dividend[28:0];
            assign pquot = '0;
            assign pdsr  = in_divisor;
            assign povf  = ovf0;
            assign pside = in_side;
        end else begin : g_rest
            assign pv    = v_reg[g-1];
            assign prem  = rem_reg[g-1];
            assign plow  = low_reg[g-1];
            assign pquot = quot_reg[g-1];
            assign pdsr  = dsr_reg[g-1];
            assign povf  = ovf_reg[g-1];
            assign pside = side_reg[g-1];
        end

        always_comb begin
            t         = {prem, plow[K]};
            quot_next = pquot;
            if (t >= {1'b0, pdsr}) begin
                rem_next     = 16'(t - {1'b0, pdsr});
                quot_next[K] = 1'b1;
            end else begin
                rem_next = t[15:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= pv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= rem_next;
                low_reg[g]  <= plow;
                quot_reg[g] <= quot_next;
                dsr_reg[g]  <= pdsr;
                ovf_reg[g]  <= povf;
                side_reg[g] <= pside;
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS-1];
    assign out_quot  = quot_reg[DIV_STEPS-1];
    assign out_ovf   = ovf_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

// ===== rtl/fr_ratio.sv =====
module fr_ratio
    import fr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [1:0][45:0] in_num,
    input  logic [1:0][45:0] in_den,
    input  fr_side_t         in_side,
    output logic             out_valid,
    output logic [1:0][18:0] out_ratio,
    output fr_side_t         out_side
);

    // num <= den, so the quotient fits in one integer bit plus 18 fraction
    // bits; two lanes share the stage control
    logic [RAT_STEPS-1:0] v_reg;
    logic [1:0][45:0]     rem_reg  [0:RAT_STEPS-1];
    logic [1:0][45:0]     den_reg  [0:RAT_STEPS-1];
    logic [1:0][18:0]     quot_reg [0:RAT_STEPS-1];
    logic [1:0]           zero_reg [0:RAT_STEPS-1];
    fr_side_t             side_reg [0:RAT_STEPS-1];

    for (genvar g = 0; g < RAT_STEPS; g++) begin : g_stage
        localparam int K = RAT_STEPS - 1 - g;
        logic             pv;
        logic [1:0][45:0] prem;
        logic [1:0][45:0] pden;
        logic [1:0][18:0] pquot;
        logic [1:0]       pzero;
        fr_side_t         pside;
        logic [1:0][45:0] rem_next;
        logic [1:0][18:0] quot_next;

        if (g == 0) begin : g_first
            assign pv       = in_valid;
            assign prem     = in_num;
            assign pden     = in_den;
            assign pquot    = '0;
            assign pzero[0] = in_den[0] == 46'd0;
            assign pzero[1] = in_den[1] == 46'd0;
            assign pside    = in_side;
        end else begin : g_rest
            assign pv    = v_reg[g-1];
            assign prem  = rem_reg[g-1];
            assign pden  = den_reg[g-1];
            assign pquot = quot_reg[g-1];
            assign pzero = zero_reg[g-1];
            assign pside = side_reg[g-1];
        end

        always_comb begin
            logic [46:0] t;
            quot_next = pquot;
            for (int l = 0; l < 2; l++) begin
                t = (g == 0) ? {1'b0, prem[l]} : {prem[l], 1'b0};
                if (t >= {1'b0, pden[l]}) begin
                    rem_next[l]     = 46'(t - {1'b0, pden[l]});
                    quot_next[l][K] = 1'b1;
                end else begin
                    rem_next[l] = t[45:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= pv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= rem_next;
                den_reg[g]  <= pden;
                quot_reg[g] <= quot_next;
                zero_reg[g] <= pzero;
                side_reg[g] <= pside;
            end
        end
    end

    // zero denominator reads as a ratio of one
    assign out_ratio[0] = zero_reg[RAT_STEPS-1][0] ? RAT_ONE : quot_reg[RAT_STEPS-1][0];
    assign out_ratio[1] = zero_reg[RAT_STEPS-1][1] ? RAT_ONE : quot_reg[RAT_STEPS-1][1];
    assign out_valid    = v_reg[RAT_STEPS-1];
    assign out_side     = side_reg[RAT_STEPS-1];

endmodule
